>>> sv/assert_macros.svh
// Assertion macros for the RTL of the escaper block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/jsesc_pkg.sv
// Package of types, codes and helper functions for the JSON string escaper
`timescale 1ns / 1ps

package jsesc_pkg;

  // Widths and reset values
  localparam int LENGTH_BITS_DEF = 16;
  localparam int MAX_LEN_W       = 16;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

  // Closing-quote status and internal error codes (shared encoding)
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_BAD_UTF8 = 2'd2;

  // Range the next continuation byte must fall in
  localparam logic [2:0] CLS_ANY  = 3'd0;  // 80..bf
  localparam logic [2:0] CLS_E0   = 3'd1;  // a0..bf
  localparam logic [2:0] CLS_ED   = 3'd2;  // 80..9f
  localparam logic [2:0] CLS_F0   = 3'd3;  // 90..bf
  localparam logic [2:0] CLS_F4   = 3'd4;  // 80..8f

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       empty_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  // Lower-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h57 + {4'd0, nib};
    end
    return ch;
  endfunction

  // Second character of a two-byte escape, zero when the byte has none
  function automatic logic [7:0] short_escape(input logic [7:0] b);
    logic [7:0] ch;
    unique case (b)
      8'h22:   ch = CH_QUOTE;
      8'h5c:   ch = CH_BSLASH;
      8'h08:   ch = 8'h62;  // b
      8'h0c:   ch = 8'h66;  // f
      8'h0a:   ch = 8'h6e;  // n
      8'h0d:   ch = 8'h72;  // r
      8'h09:   ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Continuation byte check against the expected range
  function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] cls);
    logic ok;
    unique case (cls)
      CLS_E0:  ok = (b >= 8'ha0) && (b <= 8'hbf);
      CLS_ED:  ok = (b >= 8'h80) && (b <= 8'h9f);
      CLS_F0:  ok = (b >= 8'h90) && (b <= 8'hbf);
      CLS_F4:  ok = (b >= 8'h80) && (b <= 8'h8f);
      default: ok = (b & 8'hc0) == 8'h80;
    endcase
    return ok;
  endfunction

endpackage

>>> sv/utf8_validating_json_string_escaper.sv
// Top level of the JSON string escaper with strict UTF-8 and length checking
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one string byte per input transaction (last byte marked, or an
// empty_string transaction) and streams the JSON-quoted, escaped form one byte
// per output transaction, opening quote first. The bytes are checked as
// strict UTF-8 and against max_string_len; once a fault is seen no more
// escaped bytes leave, and the closing quote (out_last) carries the status:
// 0 ok, 1 too long, 2 invalid UTF-8, so the receiver keeps or drops what it
// got. Each input transaction is worked out in the cycle it is accepted and
// its output bytes (none to eight) are loaded into an eight-byte output shift
// register that drains at one byte per cycle while out_ready is high. A new
// input transaction is taken while the last queued byte leaves, so the
// output port's one byte per cycle, held off by out_ready, sets the rate.
// max_string_len is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module utf8_validating_json_string_escaper #(
  parameter int LENGTH_BITS = jsesc_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  jsesc_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output jsesc_pkg::out_item_t           out_data,
  input  logic                           cfg_we,
  input  logic [jsesc_pkg::MAX_LEN_W-1:0] cfg_wdata
);

  import jsesc_pkg::*;

  localparam int CMP_W = (LENGTH_BITS + 1 > MAX_LEN_W) ? LENGTH_BITS + 1 : MAX_LEN_W;
  localparam int SEQ_N = 8;

  // Configuration and per-string state
  logic [MAX_LEN_W-1:0]   max_len_r;
  logic                   opened_r, opened_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [1:0]             pend_r, pend_nxt;
  logic [2:0]             cls_r, cls_nxt;
  logic [1:0]             err_r, err_nxt;

  // Output shift register
  logic [7:0] seq_r [SEQ_N];
  logic [7:0] seq_nxt [SEQ_N];
  logic [3:0] rem_r, rem_nxt;
  logic       close_r, close_nxt;
  logic [1:0] status_r, status_nxt;

  // Datapath temporaries
  logic [7:0]       b;
  logic             end_str;
  logic [CMP_W-1:0] n_ext;
  logic             too_long;
  logic [1:0]       err_a, err_b, err_c;
  logic             u_ok;
  logic [1:0]       pend_u, pend_b;
  logic [2:0]       cls_u, cls_b;
  logic [7:0]       esc;
  logic             emit;
  logic [3:0]       k;

  logic in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Take a new transaction once the queue is empty or its last byte leaves
  assign in_ready  = (rem_r == 4'd0) || ((rem_r == 4'd1) && out_ready);
  assign out_valid = (rem_r != 4'd0);

  assign out_data.out_byte = seq_r[0];
  assign out_data.out_last = close_r && (rem_r == 4'd1);
  assign out_data.status   = (close_r && (rem_r == 4'd1)) ? status_r : STATUS_OK;

  // Length check and UTF-8 decode of the incoming byte
  always_comb begin
    b        = in_data.data_byte;
    end_str  = in_data.empty_string || in_data.last;
    n_ext    = CMP_W'(count_r) + CMP_W'(1);
    too_long = n_ext > CMP_W'(max_len_r);
    err_a    = too_long ? STATUS_TOO_LONG : err_r;

    u_ok   = 1'b1;
    pend_u = pend_r;
    cls_u  = cls_r;
    if (pend_r != 2'd0) begin
      u_ok = cont_ok(b, cls_r);
      if (u_ok) begin
        pend_u = pend_r - 2'd1;
        cls_u  = CLS_ANY;
      end
    end else begin
      priority if (b <= 8'h7f) begin
        u_ok = 1'b1;
      end else if ((b >= 8'hc2) && (b <= 8'hdf)) begin
        pend_u = 2'd1;
        cls_u  = CLS_ANY;
      end else if ((b >= 8'he0) && (b <= 8'hef)) begin
        pend_u = 2'd2;
        cls_u  = (b == 8'he0) ? CLS_E0 : (b == 8'hed) ? CLS_ED : CLS_ANY;
      end else if ((b >= 8'hf0) && (b <= 8'hf4)) begin
        pend_u = 2'd3;
        cls_u  = (b == 8'hf0) ? CLS_F0 : (b == 8'hf4) ? CLS_F4 : CLS_ANY;
      end else begin
        u_ok = 1'b0;
      end
    end

    // A length fault freezes the decoder; a UTF-8 fault never replaces it
    err_b  = err_a;
    pend_b = pend_r;
    cls_b  = cls_r;
    if (err_a != STATUS_TOO_LONG) begin
      pend_b = pend_u;
      cls_b  = cls_u;
      if (!u_ok && (err_a == STATUS_OK)) begin
        err_b = STATUS_BAD_UTF8;
      end
    end

    // Empty transaction carries no byte: state as it was
    if (in_data.empty_string) begin
      err_b  = err_r;
      pend_b = pend_r;
      cls_b  = cls_r;
    end

    // Truncated sequence at end of string
    err_c = err_b;
    if (end_str && (pend_b != 2'd0) && (err_b == STATUS_OK)) begin
      err_c = STATUS_BAD_UTF8;
    end

    esc  = short_escape(b);
    emit = !in_data.empty_string && (err_b == STATUS_OK);
  end

  // Assemble the output bytes of this transaction
  always_comb begin
    for (int i = 0; i < SEQ_N; i++) begin
      seq_nxt[i] = 8'h00;
    end
    k = 4'd0;
    if (!opened_r) begin
      seq_nxt[k[2:0]] = CH_QUOTE;
      k = k + 4'd1;
    end
    if (emit) begin
      if (esc != 8'h00) begin
        seq_nxt[k[2:0]]        = CH_BSLASH;
        seq_nxt[k[2:0] + 3'd1] = esc;
        k = k + 4'd2;
      end else if (b < 8'h20) begin
        seq_nxt[k[2:0]]        = CH_BSLASH;
        seq_nxt[k[2:0] + 3'd1] = CH_U;
        seq_nxt[k[2:0] + 3'd2] = CH_ZERO;
        seq_nxt[k[2:0] + 3'd3] = CH_ZERO;
        seq_nxt[k[2:0] + 3'd4] = hex_digit(b[7:4]);
        seq_nxt[k[2:0] + 3'd5] = hex_digit(b[3:0]);
        k = k + 4'd6;
      end else begin
        seq_nxt[k[2:0]] = b;
        k = k + 4'd1;
      end
    end
    close_nxt  = end_str;
    status_nxt = err_c;
    if (end_str) begin
      seq_nxt[k[2:0]] = CH_QUOTE;
      k = k + 4'd1;
    end
  end

  // Next string state
  always_comb begin
    opened_nxt = opened_r;
    count_nxt  = count_r;
    pend_nxt   = pend_r;
    cls_nxt    = cls_r;
    err_nxt    = err_r;
    if (in_fire) begin
      if (end_str) begin
        opened_nxt = 1'b0;
        count_nxt  = '0;
        pend_nxt   = 2'd0;
        cls_nxt    = CLS_ANY;
        err_nxt    = STATUS_OK;
      end else begin
        opened_nxt = 1'b1;
        count_nxt  = (count_r == '1) ? count_r : count_r + LENGTH_BITS'(1);
        pend_nxt   = pend_b;
        cls_nxt    = cls_b;
        err_nxt    = err_b;
      end
    end
  end

  // Queue occupancy
  always_comb begin
    rem_nxt = rem_r;
    if (in_fire) begin
      rem_nxt = k;
    end else if (out_fire) begin
      rem_nxt = rem_r - 4'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      opened_r  <= 1'b0;
      count_r   <= '0;
      pend_r    <= 2'd0;
      cls_r     <= CLS_ANY;
      err_r     <= STATUS_OK;
      rem_r     <= 4'd0;
      close_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      opened_r <= opened_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      cls_r    <= cls_nxt;
      err_r    <= err_nxt;
      rem_r    <= rem_nxt;
      if (in_fire) begin
        close_r <= close_nxt;
      end
    end
  end

  // Output bytes: load on a new transaction, else shift as bytes leave
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < SEQ_N; i++) begin
        seq_r[i] <= seq_nxt[i];
      end
      status_r <= status_nxt;
    end else if (out_fire) begin
      for (int i = 0; i < SEQ_N - 1; i++) begin
        seq_r[i] <= seq_r[i+1];
      end
    end
  end

  // Checks
  `ASSERT_NOW(a_status_only_on_close, out_valid && !out_data.out_last,
              out_data.status == STATUS_OK, "status set on a non-closing byte")
  `ASSERT_NOW(a_class_needs_pending, pend_r == 2'd0, cls_r == CLS_ANY,
              "continuation class held with nothing pending")
  `ASSERT_NEXT(a_string_end_clears, in_fire && (in_data.last || in_data.empty_string),
               !opened_r && (count_r == '0) && (err_r == STATUS_OK) && out_valid,
               "string state not cleared after closing transaction")
  `ASSERT_NOW(a_queue_bound, 1'b1, rem_r <= 4'(SEQ_N),
              "output queue over its depth")

endmodule

>>> tb/tb_utf8_validating_json_string_escaper.sv
// Self-checking testbench for the UTF-8 validating JSON string escaper
`timescale 1ns / 1ps

module tb_utf8_validating_json_string_escaper;
  import jsesc_pkg::*;

  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 16;
  localparam int ITEMS_PER_PHASE = 45;

  // Control bytes with a short escape, and the letters that follow the backslash
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_FF      = 8'h0c;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] ESC_B      = 8'h62;
  localparam logic [7:0] ESC_F      = 8'h66;
  localparam logic [7:0] ESC_N      = 8'h6e;
  localparam logic [7:0] ESC_R      = 8'h72;
  localparam logic [7:0] ESC_T      = 8'h74;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [MAX_LEN_W-1:0] cfg_wdata = '0;

  in_item_t    pending_q[$];
  out_item_t   quoted_q[$];
  logic [7:0]  str_buf[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatches     = 0;
  int          phase_items    = 0;

  // Predictor state for the string in progress
  logic                 str_open   = 1'b0;
  logic [15:0]          str_len    = '0;
  logic [1:0]           cont_left  = '0;
  logic [2:0]           cont_range = CLS_ANY;
  logic [1:0]           str_err    = STATUS_OK;
  logic [MAX_LEN_W-1:0] max_len    = MAX_LEN_RESET;

  utf8_validating_json_string_escaper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return CH_LOWER_A + {4'd0, nib} - 8'd10;
  endfunction

  function automatic void push_quoted(input logic [7:0] b, input logic fin,
                                      input logic [1:0] st);
    out_item_t item;
    item = '{out_byte: b, out_last: fin, status: st};
    quoted_q.insert(quoted_q.size(), item);
  endfunction

  // Strict UTF-8 decoder step; state only moves on an accepted byte
  function automatic logic utf8_accept(input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (cont_left != 2'd0) begin
      case (cont_range)
        CLS_E0:  ok = (b >= 8'ha0) && (b <= 8'hbf);
        CLS_ED:  ok = (b >= 8'h80) && (b <= 8'h9f);
        CLS_F0:  ok = (b >= 8'h90) && (b <= 8'hbf);
        CLS_F4:  ok = (b >= 8'h80) && (b <= 8'h8f);
        default: ok = (b[7:6] == 2'b10);
      endcase
      if (ok) begin
        cont_left  = cont_left - 2'd1;
        cont_range = CLS_ANY;
      end
    end else if (b <= 8'h7f) begin
      ok = 1'b1;
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      cont_left  = 2'd1;
      cont_range = CLS_ANY;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      cont_left  = 2'd2;
      cont_range = (b == 8'he0) ? CLS_E0 : (b == 8'hed) ? CLS_ED : CLS_ANY;
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      cont_left  = 2'd3;
      cont_range = (b == 8'hf0) ? CLS_F0 : (b == 8'hf4) ? CLS_F4 : CLS_ANY;
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // Expected output bytes for one accepted input transaction
  function automatic void predict_quoted(input in_item_t it);
    logic [16:0] n;
    logic [7:0]  b;
    logic [7:0]  esc;
    b = it.data_byte;
    if (!str_open) begin
      push_quoted(CH_QUOTE, 1'b0, STATUS_OK);
      str_open = 1'b1;
    end
    if (!it.empty_string) begin
      n = {1'b0, str_len} + 17'd1;
      if (n > {1'b0, max_len}) begin
        str_err = STATUS_TOO_LONG;
      end
      str_len = n[16] ? 16'hffff : n[15:0];
      // a length error stops decoding; a UTF-8 fault never overrides it
      if (str_err != STATUS_TOO_LONG) begin
        if (!utf8_accept(b) && str_err == STATUS_OK) begin
          str_err = STATUS_BAD_UTF8;
        end
      end
      if (str_err == STATUS_OK) begin
        case (b)
          CH_QUOTE:  esc = CH_QUOTE;
          CH_BSLASH: esc = CH_BSLASH;
          CH_BS:     esc = ESC_B;
          CH_FF:     esc = ESC_F;
          CH_LF:     esc = ESC_N;
          CH_CR:     esc = ESC_R;
          CH_TAB:    esc = ESC_T;
          default:   esc = 8'h00;
        endcase
        if (esc != 8'h00) begin
          push_quoted(CH_BSLASH, 1'b0, STATUS_OK);
          push_quoted(esc, 1'b0, STATUS_OK);
        end else if (b < 8'h20) begin
          push_quoted(CH_BSLASH, 1'b0, STATUS_OK);
          push_quoted(CH_U, 1'b0, STATUS_OK);
          push_quoted(CH_ZERO, 1'b0, STATUS_OK);
          push_quoted(CH_ZERO, 1'b0, STATUS_OK);
          push_quoted(nibble_char(b[7:4]), 1'b0, STATUS_OK);
          push_quoted(nibble_char(b[3:0]), 1'b0, STATUS_OK);
        end else begin
          push_quoted(b, 1'b0, STATUS_OK);
        end
      end
    end
    // Closing quote carries the verdict; a pending sequence means truncation
    if (it.empty_string || it.last) begin
      if (cont_left != 2'd0 && str_err == STATUS_OK) begin
        str_err = STATUS_BAD_UTF8;
      end
      push_quoted(CH_QUOTE, 1'b1, str_err);
      str_open   = 1'b0;
      str_len    = '0;
      cont_left  = '0;
      cont_range = CLS_ANY;
      str_err    = STATUS_OK;
    end
  endfunction

  // Input driver: one transaction at a time from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_quoted(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare every accepted transaction with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (quoted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected output: byte %h last %b status %0d",
                   out_data.out_byte, out_data.out_last, out_data.status);
        end
      end else begin
        want = quoted_q.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last ||
            out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected %h/%b/%0d, got %h/%b/%0d (byte/last/status)",
                     want.out_byte, want.out_last, want.status,
                     out_data.out_byte, out_data.out_last, out_data.status);
          end
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic push_item(input logic [7:0] b, input logic fin, input logic empty);
    in_item_t item;
    item = '{data_byte: b, last: fin, empty_string: empty};
    pending_q.insert(pending_q.size(), item);
  endtask

  task automatic buf_byte(input logic [7:0] v);
    str_buf.insert(str_buf.size(), v);
  endtask

  // One character, mostly well-formed UTF-8 with some broken or stray bytes
  task automatic append_char();
    int unsigned kind;
    logic [7:0]  lead;
    logic [7:0]  second;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      buf_byte(rand_byte(8'h20, 8'h7e));
    end else if (kind < 42) begin
      case ($urandom_range(0, 3))
        0:       buf_byte(CH_QUOTE);
        1:       buf_byte(CH_BSLASH);
        2:       buf_byte(8'h7f);
        default: buf_byte(rand_byte(8'h00, 8'h1f));
      endcase
    end else if (kind < 57) begin
      buf_byte(rand_byte(8'hc2, 8'hdf));
      buf_byte(rand_byte(8'h80, 8'hbf));
    end else if (kind < 70) begin
      lead   = rand_byte(8'he0, 8'hef);
      second = (lead == 8'he0) ? rand_byte(8'ha0, 8'hbf) :
               (lead == 8'hed) ? rand_byte(8'h80, 8'h9f) : rand_byte(8'h80, 8'hbf);
      // now and then any continuation, to hit overlongs and surrogates
      if ($urandom_range(0, 9) == 0) begin
        second = rand_byte(8'h80, 8'hbf);
      end
      buf_byte(lead);
      buf_byte(second);
      buf_byte(rand_byte(8'h80, 8'hbf));
    end else if (kind < 82) begin
      lead   = rand_byte(8'hf0, 8'hf4);
      second = (lead == 8'hf0) ? rand_byte(8'h90, 8'hbf) :
               (lead == 8'hf4) ? rand_byte(8'h80, 8'h8f) : rand_byte(8'h80, 8'hbf);
      if ($urandom_range(0, 9) == 0) begin
        second = rand_byte(8'h80, 8'hbf);
      end
      buf_byte(lead);
      buf_byte(second);
      buf_byte(rand_byte(8'h80, 8'hbf));
      buf_byte(rand_byte(8'h80, 8'hbf));
    end else if (kind < 88) begin
      // lead byte left without its continuations
      buf_byte(rand_byte(8'hc2, 8'hf4));
    end else begin
      buf_byte(rand_byte(8'h00, 8'hff));
    end
  endtask

  task automatic add_random_string();
    int unsigned nchars;
    logic        end_empty;
    str_buf.delete();
    nchars = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
    repeat (nchars) append_char();
    end_empty = (str_buf.size() == 0) || ($urandom_range(0, 9) == 0);
    foreach (str_buf[i]) begin
      push_item(str_buf[i], !end_empty && (i == str_buf.size() - 1), 1'b0);
    end
    if (end_empty) begin
      push_item(rand_byte(8'h00, 8'hff), 1'($urandom_range(0, 1)), 1'b1);
      phase_items++;
    end
    phase_items += str_buf.size();
  endtask

  // If lim <= 8: strings at the limit and one byte over, the longer faulting early
  task automatic probe_limit(input logic [15:0] lim);
    int k;
    if (lim <= 16'd8) begin
      for (k = 0; k < int'(lim); k++) begin
        push_item(rand_byte(8'h20, 8'h7e), k == int'(lim) - 1, 1'b0);
      end
      push_item(8'hc0, lim == 16'd0, 1'b0);
      for (k = 0; k < int'(lim); k++) begin
        push_item(rand_byte(8'h20, 8'h7e), k == int'(lim) - 1, 1'b0);
      end
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // Hold off until every pending transaction is sent and every result is back
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || quoted_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_len    = v;
  endtask

  // Stimulus: directed strings at the reset limit, then random phases
  initial begin
    logic [15:0] phase_limit[6];
    logic [15:0] lim;
    int          p;
    phase_limit = '{16'd1, 16'd3, 16'hffff, 16'd0, 16'd8, 16'd2};
    set_idling(0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty string on its own
    push_item(8'hff, 1'b1, 1'b1);
    // every escape form, both ends of the \u00XX range, DEL passes through
    push_item(CH_QUOTE, 1'b0, 1'b0);
    push_item(CH_BSLASH, 1'b0, 1'b0);
    push_item(CH_BS, 1'b0, 1'b0);
    push_item(CH_FF, 1'b0, 1'b0);
    push_item(CH_LF, 1'b0, 1'b0);
    push_item(CH_CR, 1'b0, 1'b0);
    push_item(CH_TAB, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h1f, 1'b0, 1'b0);
    push_item(8'h7f, 1'b1, 1'b0);
    // highest code point U+10FFFF
    push_item(8'hf4, 1'b0, 1'b0);
    push_item(8'h8f, 1'b0, 1'b0);
    push_item(8'hbf, 1'b0, 1'b0);
    push_item(8'hbf, 1'b1, 1'b0);
    // truncated sequence ended by an empty-string transaction mid-string
    push_item(8'he2, 1'b0, 1'b0);
    push_item(8'h82, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    // surrogate: the fault swallows the rest of the string
    push_item(8'hed, 1'b0, 1'b0);
    push_item(8'ha0, 1'b0, 1'b0);
    push_item(8'h41, 1'b1, 1'b0);
    // overlong lead and a lead above U+10FFFF
    push_item(8'hc1, 1'b0, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'hf5, 1'b1, 1'b0);

    for (p = 0; p < 6; p++) begin
      wait_drained();
      lim = (p == 5) ? 16'($urandom_range(2, 40)) : phase_limit[p];
      write_max_len(lim);
      set_idling(p + 1);
      probe_limit(lim);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        add_random_string();
      end
    end

    wait_drained();
    if (mismatches == 0 && quoted_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
